>>> rtl/core/spat_pkg.sv
// shared types and constants of the stale pixel age tracker
`timescale 1ns / 1ps

package spat_pkg;

    localparam int unsigned SEC_W    = 3;
    localparam int unsigned OFF_W    = 12;
    localparam int unsigned PIX_W    = 32;
    localparam int unsigned AGE_W    = 8;
    localparam int unsigned CNT_W    = 13;

    localparam logic [AGE_W-1:0] AGE_STEP  = 8'd2;
    localparam logic [AGE_W-1:0] AGE_MAX   = 8'd255;
    localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;
    localparam logic [CNT_W-1:0] THRESHOLD_RESET = 13'd2048;

    // register map: byte addresses of the config registers
    localparam logic [1:0] REG_CLEAR_THRESHOLD = 2'd0;

    typedef enum logic {
        OP_COMPARE = 1'b0,
        OP_LOAD    = 1'b1
    } t_op;

    // one classified item as it waits between front and back
    typedef struct packed {
        t_op              op;
        logic [SEC_W-1:0] section;
        logic [OFF_W-1:0] offset;
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_item;

    // one result item
    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [AGE_W-1:0] alpha;
        logic             changed;
        logic             section_end;
        logic             section_cleared;
        logic [CNT_W-1:0] change_count;
    } t_result;

    // status from back part to front part
    typedef struct packed {
        logic init_busy;
        logic sweep_busy;
    } t_back_status;

endpackage

>>> rtl/core/spat_front.sv
// front part: input handshake, address range check and unpacking
`timescale 1ns / 1ps

module spat_front
    import spat_pkg::*;
#(
    parameter int unsigned SECTION_PIXELS = 4096,
    parameter int unsigned NUM_SECTIONS   = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [47:0]  i_data,
    input  logic         i_last,
    input  logic         i_user,
    input  t_back_status i_status,
    input  logic         i_q_full,
    output logic         o_push,
    output t_item        o_item
);

    logic [SEC_W-1:0] w_sec;
    logic [OFF_W-1:0] w_off;
    logic             w_in_range;
    logic             r_seen_item;

    assign w_sec = i_data[2:0];
    assign w_off = i_data[14:3];

    // items outside the screen are taken and dropped
    assign w_in_range = (32'(w_sec) < 32'(NUM_SECTIONS))
                     && (32'(w_off) < 32'(SECTION_PIXELS));

    assign o_ready = !i_q_full && !i_status.init_busy;
    assign o_push  = i_valid && o_ready && w_in_range;

    always_comb begin
        o_item.op      = t_op'(i_user);
        o_item.section = w_sec;
        o_item.offset  = w_off;
        o_item.pixel   = i_data[46:15];
        o_item.last    = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_item <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_seen_item <= 1'b1;
        end
    end

    // nothing gets in while the age store is still being cleared after reset
    a_no_accept_during_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.init_busy |-> !o_ready)
        else $error("item accepted during age store init");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_full |-> !o_push)
        else $error("push into full queue");

    a_first_item_after_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !r_seen_item) |-> !i_status.init_busy)
        else $error("first item accepted before init done");

endmodule

>>> rtl/core/spat_queue.sv
// short queue between front and back parts
`timescale 1ns / 1ps

module spat_queue
    import spat_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic [PTR_W:0]   n_count;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PTR_W+1)'(DEPTH))
        else $error("queue count out of range");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a push");

endmodule

>>> rtl/core/spat_back.sv
// back part: reference and age memories, age update, change counter, clear sweeps
`timescale 1ns / 1ps

module spat_back
    import spat_pkg::*;
#(
    parameter int unsigned SECTION_PIXELS = 4096,
    parameter int unsigned NUM_SECTIONS   = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_clear_threshold,
    input  logic             i_q_valid,
    input  t_item            i_q_item,
    output logic             o_q_pop,
    output t_back_status     o_status,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_result          o_out
);

    localparam int unsigned TOTAL = NUM_SECTIONS * SECTION_PIXELS;
    localparam int unsigned AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int unsigned SW    = $clog2(TOTAL + 1);

    function automatic logic [AW-1:0] addr_of(input logic [SEC_W-1:0] sec,
                                              input logic [OFF_W-1:0] off);
        logic [31:0] full;
        full = 32'(sec) * 32'(SECTION_PIXELS) + 32'(off);
        return full[AW-1:0];
    endfunction

    logic [PIX_W-1:0] r_ref_mem [TOTAL];
    logic [AGE_W-1:0] r_age_mem [TOTAL];

    logic [PIX_W-1:0] r_ref_rd;
    logic [AGE_W-1:0] r_age_rd;

    logic             r_b_valid;
    t_item            r_b_item;
    logic [AW-1:0]    r_b_addr;
    logic             r_fwd_ref_hit;
    logic [PIX_W-1:0] r_fwd_ref;
    logic             r_fwd_age_hit;
    logic [AGE_W-1:0] r_fwd_age;

    logic [SW-1:0]    r_sweep_left;
    logic [AW-1:0]    r_sweep_addr;
    logic             r_init_busy;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_result          r_out;

    logic             w_sweep_active;
    logic [AW-1:0]    w_pop_addr;
    logic             w_out_free;
    logic             w_b_compare;
    logic             w_b_done;
    logic             w_b_last_cmp;
    logic [PIX_W-1:0] w_ref_val;
    logic [AGE_W-1:0] w_age_old;
    logic [AGE_W:0]   w_age_sum;
    logic [AGE_W-1:0] w_age_new;
    logic             w_diff;
    logic [CNT_W-1:0] w_cnt_new;
    logic             w_cleared;

    assign w_sweep_active = (r_sweep_left != '0);
    assign w_pop_addr     = addr_of(i_q_item.section, i_q_item.offset);
    assign w_out_free     = !r_out_valid || i_out_ready;
    assign w_b_compare    = (r_b_item.op == OP_COMPARE);
    assign w_b_done       = r_b_valid && (!w_b_compare || w_out_free);
    assign w_b_last_cmp   = r_b_valid && w_b_compare && r_b_item.last;

    // no read in the shadow of a section end, so a clear sweep can start before the next read
    assign o_q_pop = i_q_valid && !w_sweep_active
                  && (!r_b_valid || (w_b_done && !w_b_last_cmp));

    assign o_status.init_busy  = r_init_busy;
    assign o_status.sweep_busy = w_sweep_active;

    always_comb begin
        w_ref_val = r_fwd_ref_hit ? r_fwd_ref : r_ref_rd;
        w_age_old = r_fwd_age_hit ? r_fwd_age : r_age_rd;
        w_diff    = (w_ref_val != r_b_item.pixel);
        w_age_sum = {1'b0, w_age_old} + {1'b0, AGE_STEP};
        if (w_diff) begin
            w_age_new = '0;
        end else if (w_age_sum > {1'b0, AGE_MAX}) begin
            w_age_new = AGE_MAX;
        end else begin
            w_age_new = w_age_sum[AGE_W-1:0];
        end
        w_cnt_new = r_count;
        if (w_diff && (r_count != COUNT_MAX)) begin
            w_cnt_new = r_count + 1'b1;
        end
        w_cleared = r_b_item.last && (w_cnt_new > i_clear_threshold);
        n_count   = r_count;
        if (w_b_done && w_b_compare) begin
            n_count = r_b_item.last ? '0 : w_cnt_new;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid    <= 1'b0;
            r_sweep_left <= SW'(TOTAL);
            r_sweep_addr <= '0;
            r_init_busy  <= 1'b1;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_count <= n_count;
            if (o_q_pop) begin
                r_b_valid <= 1'b1;
            end else if (w_b_done) begin
                r_b_valid <= 1'b0;
            end
            if (w_sweep_active) begin
                r_sweep_left <= r_sweep_left - 1'b1;
                r_sweep_addr <= r_sweep_addr + 1'b1;
                if (r_sweep_left == SW'(1)) begin
                    r_init_busy <= 1'b0;
                end
            end else if (w_b_done && w_b_compare && w_cleared) begin
                r_sweep_left <= SW'(SECTION_PIXELS);
                r_sweep_addr <= addr_of(r_b_item.section, '0);
            end
            if (w_b_done && w_b_compare) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and forwarding of a write that lands on the edge of the next read
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_b_item      <= i_q_item;
            r_b_addr      <= w_pop_addr;
            r_fwd_ref_hit <= w_b_done && !w_b_compare && (r_b_addr == w_pop_addr);
            r_fwd_ref     <= r_b_item.pixel;
            r_fwd_age_hit <= w_b_done && w_b_compare && (r_b_addr == w_pop_addr);
            r_fwd_age     <= w_age_new;
        end
        if (w_b_done && w_b_compare) begin
            r_out.offset          <= r_b_item.offset;
            r_out.alpha           <= w_cleared ? '0 : w_age_new;
            r_out.changed         <= w_diff;
            r_out.section_end     <= r_b_item.last;
            r_out.section_cleared <= w_cleared;
            r_out.change_count    <= w_cnt_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_done && !w_b_compare) begin
            r_ref_mem[r_b_addr] <= r_b_item.pixel;
        end
        if (o_q_pop) begin
            r_ref_rd <= r_ref_mem[w_pop_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sweep_active) begin
            r_age_mem[r_sweep_addr] <= '0;
        end else if (w_b_done && w_b_compare) begin
            r_age_mem[r_b_addr] <= w_age_new;
        end
        if (o_q_pop) begin
            r_age_rd <= r_age_mem[w_pop_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_no_read_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sweep_active |-> !o_q_pop)
        else $error("memory read while a clear sweep runs");

    a_sweep_owns_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sweep_active |-> !r_b_valid)
        else $error("age write collides with clear sweep");

    a_clear_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_b_done && w_b_compare && w_cleared) |=> w_sweep_active)
        else $error("cleared section without sweep");

    a_count_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_b_done && w_b_last_cmp) |=> (r_count == '0))
        else $error("change count kept after section end");

    a_no_pop_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_b_last_cmp |-> !o_q_pop)
        else $error("item read in the shadow of a section end");

endmodule

>>> rtl/core/stale_pixel_age_tracker_unit.sv
// top level of the stale pixel age tracker: config register and part wiring
`timescale 1ns / 1ps

// Stale pixel age tracker. Each item addresses one pixel by section and
// offset. A load item (tuser 1) stores the reference pixel; a compare item
// (tuser 0) checks the pixel against its reference, sets its age to 0 on a
// change or raises it by 2 up to 255, and returns one result item with the
// alpha, the changed flag and the running change count of the section pass.
// The compare item with tlast closes the pass: when the count is above
// clear_threshold, the result carries tuser 1 and alpha 0, and every age of
// the section returns to zero. Items whose section or offset lies outside
// the screen are taken and dropped. Throughput is one item per clock while the
// result stream takes results and no clear sweep runs; a read is held back
// after a section end, and a section clear stalls the back part while the age
// memory's single write port zeroes the section (the input queue of four items
// keeps taking items meanwhile). After reset the age memory is zeroed over all
// NUM_SECTIONS * SECTION_PIXELS entries, one entry a cycle, and s_axis_tready
// stays low until that ends; the config port works throughout. A result item
// passes the input queue, the back item register and the result register.
// clear_threshold may be written only when idle.

module stale_pixel_age_tracker_unit
    import spat_pkg::*;
#(
    parameter int unsigned SECTION_PIXELS = 4096,
    parameter int unsigned NUM_SECTIONS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // section[2:0], offset[14:3], pixel[46:15], zero[47]
    input  logic        s_axis_tlast,  // last_in_section
    input  logic        s_axis_tuser,  // operation: 0 compare, 1 load

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // out_offset[11:0], alpha[19:12], changed[20],
                                       // change_count[33:21], zero[39:34]
    output logic        m_axis_tlast,  // section_end
    output logic        m_axis_tuser,  // section_cleared

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // the single register, clear_threshold, sits at byte address 0
    logic [CNT_W-1:0] r_clear_threshold;

    t_back_status w_status;
    logic         w_q_full;
    logic         w_push;
    t_item        w_push_item;
    logic         w_q_valid;
    t_item        w_q_item;
    logic         w_pop;
    t_result      w_out;

    assign pready = 1'b1;
    assign prdata = {{(32 - CNT_W){1'b0}}, r_clear_threshold};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_threshold <= THRESHOLD_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr == REG_CLEAR_THRESHOLD)) begin
            r_clear_threshold <= pwdata[CNT_W-1:0];
        end
    end

    // front: takes items, drops off-screen ones, feeds the queue
    spat_front #(
        .SECTION_PIXELS (SECTION_PIXELS),
        .NUM_SECTIONS   (NUM_SECTIONS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_data   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_user   (s_axis_tuser),
        .i_status (w_status),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_item   (w_push_item)
    );

    // decouples input from memory stalls (sweeps, output back-pressure)
    spat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    // back: memory read, compare and age update, result register
    spat_back #(
        .SECTION_PIXELS (SECTION_PIXELS),
        .NUM_SECTIONS   (NUM_SECTIONS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_clear_threshold (r_clear_threshold),
        .i_q_valid         (w_q_valid),
        .i_q_item          (w_q_item),
        .o_q_pop           (w_pop),
        .o_status          (w_status),
        .o_out_valid       (m_axis_tvalid),
        .i_out_ready       (m_axis_tready),
        .o_out             (w_out)
    );

    assign m_axis_tdata = {6'd0, w_out.change_count, w_out.changed, w_out.alpha,
                           w_out.offset};
    assign m_axis_tlast = w_out.section_end;
    assign m_axis_tuser = w_out.section_cleared;

endmodule

>>> verif/tb_top.sv
// testbench for the stale pixel age tracker: stimulus, age prediction and result checks
`timescale 1ns / 1ps

module tb_top;
    import spat_pkg::*;

    localparam int unsigned SECTION_PIXELS = 4096;
    localparam int unsigned NUM_SECTIONS   = 8;
    localparam int unsigned SCREEN_PIXELS  = SECTION_PIXELS * NUM_SECTIONS;
    // a section clear sweeps the whole section one entry per cycle
    localparam int unsigned SETTLE_CYCLES  = SECTION_PIXELS + 64;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // input stream
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;  // section[2:0], offset[14:3], pixel[46:15], zero[47]
    logic        s_axis_tlast  = 1'b0; // last_in_section
    logic        s_axis_tuser  = 1'b0; // operation: 0 compare, 1 load

    // result stream
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;  // out_offset[11:0], alpha[19:12], changed[20],
                                // change_count[33:21], zero[39:34]
    logic        m_axis_tlast;  // section_end
    logic        m_axis_tuser;  // section_cleared

    // config port
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [1:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    stale_pixel_age_tracker_unit #(
        .SECTION_PIXELS(SECTION_PIXELS),
        .NUM_SECTIONS  (NUM_SECTIONS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // age predictor: own copy of reference pixels, ages, counter, threshold
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] ref_pix [0:SCREEN_PIXELS-1];
    logic [AGE_W-1:0] pix_age [0:SCREEN_PIXELS-1];
    logic [CNT_W-1:0] run_changes = '0;
    logic [CNT_W-1:0] clear_level = THRESHOLD_RESET;

    t_item   pixel_feed [$];   // items waiting to be sent
    t_result due_ages   [$];   // predicted results, oldest first
    t_item   on_bus;           // item currently offered on the input stream

    int unsigned mismatches    = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // one accepted item: returns 1 and the result when a compare produces one
    function automatic bit age_pixel(input t_item it, output t_result res);
        logic [14:0]      a;
        logic [AGE_W:0]   grown;
        logic [AGE_W-1:0] age;
        bit               diff;
        a   = {it.section, it.offset};
        res = '0;
        if (it.op == OP_LOAD) begin
            ref_pix[a] = it.pixel;
            return 1'b0;
        end
        diff = (ref_pix[a] != it.pixel);
        if (diff) begin
            age = '0;
            if (run_changes != COUNT_MAX)
                run_changes = run_changes + 1'b1;
        end else begin
            grown = {1'b0, pix_age[a]} + {1'b0, AGE_STEP};
            age   = (grown > {1'b0, AGE_MAX}) ? AGE_MAX : grown[AGE_W-1:0];
        end
        pix_age[a]       = age;
        res.offset       = it.offset;
        res.changed      = diff;
        res.section_end  = it.last;
        res.change_count = run_changes;
        if (it.last) begin
            // pass over the threshold wipes every age of the section
            if (run_changes > clear_level) begin
                for (int k = 0; k < SECTION_PIXELS; k++)
                    pix_age[{it.section, k[OFF_W-1:0]}] = '0;
                res.section_cleared = 1'b1;
                age = '0;
            end
            run_changes = '0;
        end
        res.alpha = age;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string field, input longint unsigned want,
                                 input longint unsigned got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // ------------------------------------------------------------------
    // input driver: offers queued items, predicts each one as it is taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : feed_driver
        t_result res;
        bit      take;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (age_pixel(on_bus, res))
                    due_ages.push_back(res);
            end
            // move on once the offered item is taken or nothing is offered
            if (!s_axis_tvalid || s_axis_tready) begin
                take = (pixel_feed.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
                if (take) begin
                    on_bus       = pixel_feed.pop_front();
                    s_axis_tdata <= {1'b0, on_bus.pixel, on_bus.offset, on_bus.section};
                    s_axis_tlast <= on_bus.last;
                    s_axis_tuser <= on_bus.op;
                end
                s_axis_tvalid <= take;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: random backpressure, field-by-field check
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.offset          = m_axis_tdata[11:0];
                got.alpha           = m_axis_tdata[19:12];
                got.changed         = m_axis_tdata[20];
                got.change_count    = m_axis_tdata[33:21];
                got.section_end     = m_axis_tlast;
                got.section_cleared = m_axis_tuser;
                if (due_ages.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, got);
                end else begin
                    want = due_ages.pop_front();
                    if (got.offset !== want.offset)
                        flag_mismatch("out_offset", want.offset, got.offset);
                    if (got.alpha !== want.alpha)
                        flag_mismatch("alpha", want.alpha, got.alpha);
                    if (got.changed !== want.changed)
                        flag_mismatch("changed", want.changed, got.changed);
                    if (got.section_end !== want.section_end)
                        flag_mismatch("section_end", want.section_end, got.section_end);
                    if (got.section_cleared !== want.section_cleared)
                        flag_mismatch("section_cleared", want.section_cleared,
                                      got.section_cleared);
                    if (got.change_count !== want.change_count)
                        flag_mismatch("change_count", want.change_count, got.change_count);
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus side: mirror of loaded references so compares stay legal
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] feed_ref [0:SCREEN_PIXELS-1];
    logic [14:0]      loaded_addrs [$];
    logic [OFF_W-1:0] hot_off [0:NUM_SECTIONS-1][0:7];  // per-section working set
    int unsigned      feed_count = 0;

    task automatic push_item(input t_op op, input logic [SEC_W-1:0] sec,
                             input logic [OFF_W-1:0] off, input logic [PIX_W-1:0] pix,
                             input bit last);
        t_item it;
        it.op      = op;
        it.section = sec;
        it.offset  = off;
        it.pixel   = pix;
        it.last    = last;
        if (op == OP_LOAD) begin
            feed_ref[{sec, off}] = pix;
            loaded_addrs.push_back({sec, off});
        end
        pixel_feed.push_back(it);
        feed_count++;
    endtask

    // compare on a loaded pixel, either equal to its reference or not
    task automatic push_compare(input logic [SEC_W-1:0] sec, input logic [OFF_W-1:0] off,
                                input bit match, input bit last);
        logic [PIX_W-1:0] pix;
        pix = feed_ref[{sec, off}];
        if (!match)
            pix = pix ^ ($urandom | 32'd1);
        push_item(OP_COMPARE, sec, off, pix, last);
    endtask

    // one section pass: mostly well-formed, some stray loads, other sections
    // and dropped pass ends mixed in
    task automatic run_pass();
        logic [SEC_W-1:0] sec;
        logic [SEC_W-1:0] s2;
        logic [OFF_W-1:0] off;
        logic [14:0]      a;
        int unsigned      len;
        int unsigned      r;
        int unsigned      k;
        bit               last;
        bit               drop_last;
        sec = SEC_W'($urandom_range(0, NUM_SECTIONS - 1));
        if ($urandom_range(0, 9) == 0) begin
            // static screen area: one pixel keeps matching, age climbs toward the cap
            len = $urandom_range(64, 160);
            for (int i = 0; i < len; i++)
                push_compare(sec, hot_off[sec][0], 1'b1, i == len - 1);
        end else begin
            len       = $urandom_range(1, 24);
            drop_last = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++) begin
                r    = $urandom_range(0, 99);
                last = (i == len - 1) && !drop_last;
                if (r < 8 && i != len - 1) begin
                    push_item(OP_LOAD, sec, hot_off[sec][$urandom_range(1, 7)], $urandom,
                              1'($urandom_range(0, 1)));
                end else if (r < 12 && i != len - 1) begin
                    push_item(OP_LOAD, SEC_W'($urandom_range(0, NUM_SECTIONS - 1)),
                              OFF_W'($urandom_range(0, SECTION_PIXELS - 1)), $urandom,
                              1'($urandom_range(0, 1)));
                end else begin
                    s2 = (r < 20) ? SEC_W'($urandom_range(0, NUM_SECTIONS - 1)) : sec;
                    if ($urandom_range(0, 99) < 85) begin
                        k   = $urandom_range(0, 7);
                        off = hot_off[s2][k];
                        push_compare(s2, off, (k == 0) || ($urandom_range(0, 99) < 75),
                                     last);
                    end else begin
                        a = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
                        push_compare(a[14:12], a[11:0], $urandom_range(0, 99) < 75, last);
                    end
                end
            end
        end
    endtask

    task automatic fill_random(input int unsigned n);
        int unsigned stop_at;
        stop_at = feed_count + n;
        while (feed_count < stop_at)
            run_pass();
    endtask

    // block idle: nothing queued, nothing offered, nothing outstanding,
    // then room for a clear sweep to finish
    task automatic settle();
        while (pixel_feed.size() != 0 || s_axis_tvalid || due_ages.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // setup and access cycles for a write, then a read back of the register
    task automatic set_clear_threshold(input logic [CNT_W-1:0] level);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_CLEAR_THRESHOLD;
        pwdata  <= {{(32 - CNT_W){1'b0}}, level};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        clear_level = level;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[CNT_W-1:0] !== level)
            flag_mismatch("clear_threshold read", level, prdata[CNT_W-1:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < SCREEN_PIXELS; i++) begin
            pix_age[i]  = '0;
            ref_pix[i]  = '0;
            feed_ref[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase 1: default threshold, sparse sender gaps, heavy backpressure
        send_idle_pct = 8;
        recv_idle_pct = 79;
        // corner pixels: first and last section and offset, all-zero and all-one words
        push_item(OP_LOAD, 3'd0, 12'd0, 32'h0000_0000, 1'b0);
        push_item(OP_LOAD, 3'd7, 12'd4095, 32'hFFFF_FFFF, 1'b1);  // tlast ignored on load
        push_item(OP_LOAD, 3'd5, 12'hAAA, 32'h5555_5555, 1'b1);
        push_item(OP_COMPARE, 3'd0, 12'd0, 32'h0000_0000, 1'b0);      // match
        push_item(OP_COMPARE, 3'd7, 12'd4095, 32'hFFFF_FFFF, 1'b0);   // match
        push_item(OP_COMPARE, 3'd0, 12'd0, 32'h0000_0000, 1'b0);      // age keeps rising
        push_item(OP_COMPARE, 3'd7, 12'd4095, 32'h0000_0000, 1'b0);   // change, age back to 0
        push_item(OP_COMPARE, 3'd5, 12'hAAA, 32'hAAAA_AAAA, 1'b1);    // pass end below threshold
        push_item(OP_COMPARE, 3'd7, 12'd4095, 32'hFFFF_FFFF, 1'b1);   // end with zero changes
        // working sets of every section get their references first
        for (int s = 0; s < NUM_SECTIONS; s++) begin
            for (int k = 0; k < 8; k++) begin
                hot_off[s][k] = OFF_W'($urandom_range(0, SECTION_PIXELS - 1));
                push_item(OP_LOAD, SEC_W'(s), hot_off[s][k], $urandom,
                          1'($urandom_range(0, 1)));
            end
        end
        fill_random(250);
        settle();

        // phase 2: threshold at its floor, any change clears on pass end
        set_clear_threshold(13'd0);
        send_idle_pct = 79;
        recv_idle_pct = 8;
        push_compare(3'd2, hot_off[2][1], 1'b0, 1'b1);  // one change ends the pass: clear
        push_compare(3'd2, hot_off[2][0], 1'b1, 1'b1);  // count equals threshold: no clear
        fill_random(250);
        settle();

        // phase 3: threshold at 4096, no idling; a long pass of changes
        // stays under it and clears nothing
        set_clear_threshold(13'd4096);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 40; i++)
            push_compare(3'd3, hot_off[3][$urandom_range(0, 7)], 1'b0, i == 39);
        fill_random(100);
        settle();

        // phase 4: small random threshold, clears come often
        set_clear_threshold(CNT_W'($urandom_range(1, 12)));
        fill_random(100);
        settle();

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog: well beyond the slowest legal run including the reset sweep
    initial begin
        #30_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
